/* hw/rtl/lcsm_pkg.sv */
`timescale 1ns / 1ps

package lcsm_pkg;

   typedef enum logic [2:0] {
      ST_START   = 3'd0,
      ST_IDENT   = 3'd1,
      ST_NUMBER  = 3'd2,
      ST_DECIMAL = 3'd3,
      ST_OPER    = 3'd4,
      ST_EXPEQ   = 3'd5,
      ST_UNKNOWN = 3'd6
   } lexer_state_type;

   typedef enum logic [2:0] {
      ACT_CONTINUE     = 3'd0,
      ACT_IGNORE       = 3'd1,
      ACT_REPLAY       = 3'd2,
      ACT_SAVE         = 3'd3,
      ACT_SAVE_REPLAY  = 3'd4,
      ACT_INFER        = 3'd5,
      ACT_INFER_REPLAY = 3'd6,
      ACT_ERROR        = 3'd7
   } action_type;

   typedef enum logic [3:0] {
      TOK_NONE     = 4'd0,
      TOK_IDENT    = 4'd1,
      TOK_NUMBER   = 4'd2,
      TOK_LPAREN   = 4'd3,
      TOK_RPAREN   = 4'd4,
      TOK_LBRACE   = 4'd5,
      TOK_RBRACE   = 4'd6,
      TOK_PERCENT  = 4'd7,
      TOK_DOT      = 4'd8,
      TOK_QUESTION = 4'd9
   } token_kind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } char_item_type;

   typedef struct packed {
      action_type     action;
      token_kind_type token_kind;
   } lex_result_type;

   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_PERCENT    = 8'h25;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_LESS       = 8'h3C;
   localparam logic [7:0] CH_EQUALS     = 8'h3D;
   localparam logic [7:0] CH_GREATER    = 8'h3E;
   localparam logic [7:0] CH_QUESTION   = 8'h3F;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      case (c) inside
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUALS, CH_LPAREN, CH_RPAREN,
         CH_LBRACE, CH_RBRACE, CH_LESS, CH_GREATER, CH_PERCENT, CH_DOT,
         CH_QUESTION: hit = 1'b1;
         default:     hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

/* hw/rtl/lcsm_if.sv */
`timescale 1ns / 1ps

interface lcsm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, output ch, output end_of_input, input ready);
   modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface lcsm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [3:0] token_kind;

   modport source (output valid, output action, output token_kind, input ready);
   modport sink   (input valid, input action, input token_kind, output ready);
endinterface

/* hw/rtl/lcsm_fsm.sv */
`timescale 1ns / 1ps

module lcsm_fsm (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  lcsm_pkg::char_item_type item,
   output lcsm_pkg::lex_result_type result
);
   import lcsm_pkg::*;

   lexer_state_type state_ff;
   lexer_state_type state_in;
   logic [7:0]      c;

   // end of input counts as a space
   assign c = item.end_of_input ? CH_SPACE : item.ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDENT: begin
            if (is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE)) begin
               state_in = ST_IDENT;
            end else if (is_space(c) || is_op(c)) begin
               state_in = ST_START;
            end else begin
               state_in = ST_UNKNOWN;
            end
         end
         ST_NUMBER, ST_DECIMAL: begin
            if (is_digit(c)) begin
               state_in = state_ff;
            end else if ((state_ff == ST_NUMBER) && (c == CH_DOT)) begin
               state_in = ST_DECIMAL;
            end else if (is_space(c) || is_op(c)) begin
               state_in = ST_START;
            end else begin
               state_in = ST_UNKNOWN;
            end
         end
         ST_OPER: begin
            unique case (c) inside
               CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUALS, CH_LESS,
               CH_GREATER: state_in = ST_EXPEQ;
               CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_PERCENT, CH_DOT,
               CH_QUESTION: state_in = ST_START;
               default:     state_in = ST_UNKNOWN;
            endcase
         end
         ST_EXPEQ: begin
            state_in = ST_START;
         end
         ST_UNKNOWN: begin
            state_in = is_space(c) ? ST_START : ST_UNKNOWN;
         end
         default: begin
            if (is_alpha(c) || (c == CH_UNDERSCORE)) begin
               state_in = ST_IDENT;
            end else if (is_digit(c)) begin
               state_in = ST_NUMBER;
            end else if (is_space(c)) begin
               state_in = ST_START;
            end else if (is_op(c)) begin
               state_in = ST_OPER;
            end else begin
               state_in = ST_UNKNOWN;
            end
         end
      endcase
   end

   always_comb begin
      result.action     = ACT_CONTINUE;
      result.token_kind = TOK_NONE;
      unique case (state_ff)
         ST_IDENT: begin
            if (is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE)) begin
               result.action = ACT_CONTINUE;
            end else if (is_space(c) || is_op(c)) begin
               result.action     = ACT_SAVE_REPLAY;
               result.token_kind = TOK_IDENT;
            end else begin
               result.action = ACT_ERROR;
            end
         end
         ST_NUMBER, ST_DECIMAL: begin
            if (is_digit(c)) begin
               result.action = ACT_CONTINUE;
            end else if ((state_ff == ST_NUMBER) && (c == CH_DOT)) begin
               result.action = ACT_CONTINUE;
            end else if (is_space(c) || is_op(c)) begin
               result.action     = ACT_SAVE_REPLAY;
               result.token_kind = TOK_NUMBER;
            end else begin
               result.action = ACT_ERROR;
            end
         end
         ST_OPER: begin
            unique case (c) inside
               CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUALS, CH_LESS,
               CH_GREATER: result.action = ACT_CONTINUE;
               CH_LPAREN: begin
                  result.action     = ACT_SAVE;
                  result.token_kind = TOK_LPAREN;
               end
               CH_RPAREN: begin
                  result.action     = ACT_SAVE;
                  result.token_kind = TOK_RPAREN;
               end
               CH_LBRACE: begin
                  result.action     = ACT_SAVE;
                  result.token_kind = TOK_LBRACE;
               end
               CH_RBRACE: begin
                  result.action     = ACT_SAVE;
                  result.token_kind = TOK_RBRACE;
               end
               CH_PERCENT: begin
                  result.action     = ACT_SAVE;
                  result.token_kind = TOK_PERCENT;
               end
               CH_DOT: begin
                  result.action     = ACT_SAVE;
                  result.token_kind = TOK_DOT;
               end
               CH_QUESTION: begin
                  result.action     = ACT_SAVE;
                  result.token_kind = TOK_QUESTION;
               end
               default: result.action = ACT_ERROR;
            endcase
         end
         ST_EXPEQ: begin
            result.action = (c == CH_EQUALS) ? ACT_INFER : ACT_INFER_REPLAY;
         end
         ST_UNKNOWN: begin
            result.action = ACT_CONTINUE;
         end
         default: begin
            if (is_alpha(c) || (c == CH_UNDERSCORE) || is_digit(c)) begin
               result.action = ACT_CONTINUE;
            end else if (is_space(c)) begin
               result.action = ACT_IGNORE;
            end else if (is_op(c)) begin
               result.action = ACT_REPLAY;
            end else begin
               result.action = ACT_ERROR;
            end
         end
      endcase
   end

endmodule

/* hw/rtl/lexer_char_state_machine_core.sv */
`timescale 1ns / 1ps

// Character lexer step: one byte (or end-of-input mark) per request word, one
// action/token word per response word, in order. Sustains one word per cycle
// while the response side is ready; each word passes the input register, then
// the lexer state update into the response register. The state advances only
// when a word moves from the input register into the response register, so
// stalls on either side never skip or repeat a character. Reset puts the lexer in the start state.

module lexer_char_state_machine_core (
   input logic          clock,
   input logic          reset,
   lcsm_req_if.sink     req_port,
   lcsm_rsp_if.source   rsp_port
);
   import lcsm_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   char_item_type  in_item_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   lex_result_type out_result_ff;
   lex_result_type step_result;
   logic           advance;
   logic           req_take;

   assign advance        = in_valid_ff & (~out_valid_ff | rsp_port.ready);
   assign req_port.ready = ~in_valid_ff | advance;
   assign req_take       = req_port.valid & req_port.ready;
   assign in_valid_in    = req_take | (in_valid_ff & ~advance);
   assign out_valid_in   = advance | (out_valid_ff & ~rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.ch           <= req_port.ch;
         in_item_ff.end_of_input <= req_port.end_of_input;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   lcsm_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (step_result)
   );

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.action     = out_result_ff.action;
   assign rsp_port.token_kind = out_result_ff.token_kind;

endmodule

/* hw/rtl/lcsm_checker.sv */
`timescale 1ns / 1ps

module lcsm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_action,
   input logic [3:0] rsp_token_kind
);
   import lcsm_pkg::*;

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_action) && $stable(rsp_token_kind));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("response word changed while stalled");

   property p_idle_after_reset;
      @(posedge clock) $past(reset) |-> !rsp_valid;
   endproperty
   a_idle_after_reset: assert property (p_idle_after_reset)
      else $error("response valid right after reset");

   property p_token_only_on_save;
      @(posedge clock) disable iff (reset)
         (rsp_valid && (rsp_action != ACT_SAVE) && (rsp_action != ACT_SAVE_REPLAY))
            |-> (rsp_token_kind == TOK_NONE);
   endproperty
   a_token_only_on_save: assert property (p_token_only_on_save)
      else $error("token kind set on a non-save action");

   property p_save_replay_kind;
      @(posedge clock) disable iff (reset)
         (rsp_valid && (rsp_action == ACT_SAVE_REPLAY))
            |-> ((rsp_token_kind == TOK_IDENT) || (rsp_token_kind == TOK_NUMBER));
   endproperty
   a_save_replay_kind: assert property (p_save_replay_kind)
      else $error("save-replay without identifier or number token");

   property p_save_kind;
      @(posedge clock) disable iff (reset)
         (rsp_valid && (rsp_action == ACT_SAVE))
            |-> ((rsp_token_kind >= TOK_LPAREN) && (rsp_token_kind <= TOK_QUESTION));
   endproperty
   a_save_kind: assert property (p_save_kind)
      else $error("save without a symbol token");

endmodule

bind lexer_char_state_machine_core lcsm_checker u_lcsm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_action     (rsp_port.action),
   .rsp_token_kind (rsp_port.token_kind)
);
